// File: hw/rtl/ljdt_pkg.sv
// shared types, constants and helpers of the leg joint dynamics tick
package ljdt_pkg;

  // timestamp
  localparam logic [29:0] TICK_NS    = 30'd1000000;
  localparam logic [30:0] NS_PER_SEC = 31'd1000000000;

  // joint geometry, Q16.16 radians
  localparam logic signed [31:0] HIP_CENTER          = 32'sd308831;
  localparam logic signed [31:0] HALF_A_RESET        = 32'sd51472;
  localparam logic signed [31:0] HALF_B_RESET        = 32'sd154416;
  localparam logic signed [31:0] HIP_RELAXED_OFFSET  = 32'sd19661;
  localparam logic signed [31:0] HIP_EXTENDED_OFFSET = 32'sd19661;
  localparam logic signed [31:0] LEFT_HIP_MIN  = HIP_CENTER - HIP_RELAXED_OFFSET;
  localparam logic signed [31:0] LEFT_HIP_MAX  = HIP_CENTER + HIP_EXTENDED_OFFSET;
  localparam logic signed [31:0] RIGHT_HIP_MIN = HIP_CENTER - HIP_EXTENDED_OFFSET;
  localparam logic signed [31:0] RIGHT_HIP_MAX = HIP_CENTER + HIP_RELAXED_OFFSET;

  // floor(y / 125) = (y * RECIP_125) >> 37 for y below 2^30
  localparam logic [30:0] RECIP_125   = 31'd1099511628;
  localparam int          RECIP_SHIFT = 37;

  // register indexes
  localparam logic [3:0] CFG_HIP_GAIN      = 4'd0;
  localparam logic [3:0] CFG_HIP_HOLD      = 4'd1;
  localparam logic [3:0] CFG_LEG_GAIN      = 4'd2;
  localparam logic [3:0] CFG_LEG_FRICTION  = 4'd3;
  localparam logic [3:0] CFG_HALF_A_MIN    = 4'd4;
  localparam logic [3:0] CFG_HALF_A_MAX    = 4'd5;
  localparam logic [3:0] CFG_HALF_B_MIN    = 4'd6;
  localparam logic [3:0] CFG_HALF_B_MAX    = 4'd7;

  // joint indexes
  localparam logic [2:0] J_LEFT_HIP  = 3'd0;
  localparam logic [2:0] J_RIGHT_HIP = 3'd1;
  localparam logic [2:0] J_LEFT_A    = 3'd2;
  localparam logic [2:0] J_LEFT_B    = 3'd3;
  localparam logic [2:0] J_RIGHT_A   = 3'd4;
  localparam logic [2:0] J_RIGHT_B   = 3'd5;

  localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
  localparam logic signed [49:0] S32_MIN = -50'sd2147483648;

  typedef struct packed {
    logic signed [31:0] left_hip_current;
    logic signed [31:0] right_hip_current;
    logic signed [31:0] left_a_current;
    logic signed [31:0] left_b_current;
    logic signed [31:0] right_a_current;
    logic signed [31:0] right_b_current;
  } ljdt_in_t;

  typedef struct packed {
    logic [2:0]         joint_index;
    logic signed [31:0] joint_angle;
    logic signed [31:0] joint_velocity;
    logic [31:0]        stamp_seconds;
    logic [29:0]        stamp_nanoseconds;
    logic               last_of_tick;
  } ljdt_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] reset_angle(input logic [2:0] j);
    logic signed [31:0] r;
    case (j)
      J_LEFT_HIP, J_RIGHT_HIP: r = HIP_CENTER;
      J_LEFT_A, J_RIGHT_A:     r = HALF_A_RESET;
      default:                 r = HALF_B_RESET;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] pick_current(input ljdt_in_t d, input logic [2:0] j);
    logic signed [31:0] r;
    case (j)
      J_LEFT_HIP:  r = d.left_hip_current;
      J_RIGHT_HIP: r = d.right_hip_current;
      J_LEFT_A:    r = d.left_a_current;
      J_LEFT_B:    r = d.left_b_current;
      J_RIGHT_A:   r = d.right_a_current;
      default:     r = d.right_b_current;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/leg_joint_dynamics_tick.sv
// top level: six-joint leg dynamics tick with one shared multiplier
// One request carries six motor currents and produces six joint results (left hip, right hip,
// left A, left B, right A, right B) in that order, each with the new angle, the new velocity
// and the timestamp after the tick; last_of_tick marks the sixth. The block takes one request
// at a time and stalls new requests until the sixth result is written. Each joint runs seven
// sequencer steps (current offset, gain multiply, velocity sum, friction, limit and rounding
// prep, divide-by-1000 multiply, angle update), and the angle update waits while the output
// register still holds a stalled result. Both multiplies of a joint go through the same 33x33
// signed multiplier. Configuration writes are always ready
// and should be made while no tick is in flight.
module leg_joint_dynamics_tick import ljdt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ljdt_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ljdt_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_AMP  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_VEL  = 3'd3;
  localparam logic [2:0] ST_FRIC = 3'd4;
  localparam logic [2:0] ST_LIM  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_ANG  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] joint_r, joint_nxt;
  ljdt_in_t   cur_r, cur_nxt;

  logic signed [31:0] hip_gain_r, hip_hold_r, leg_gain_r;
  logic [30:0]        fric_r;
  logic signed [31:0] a_min_r, a_max_r, b_min_r, b_max_r;

  logic signed [31:0] ang_r [6];
  logic signed [31:0] vel_r [6];
  logic [31:0] sec_r, sec_nxt;
  logic [29:0] ns_r, ns_nxt;

  logic signed [32:0] amps_r, amps_nxt;
  logic signed [65:0] prod_r, prod_nxt;
  logic signed [31:0] vwork_r, vwork_nxt;
  logic [31:0]        x_r, x_nxt;
  logic               neg_r, neg_nxt;

  logic      out_valid_r, out_valid_nxt;
  ljdt_out_t out_r, out_nxt;

  logic               wr_en;
  logic signed [31:0] wr_ang;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic signed [31:0] cur_sel, vold, pos, lo, hi, vlim;
  logic signed [32:0] v33, fric_s;
  logic signed [49:0] vsum, asum;
  logic [26:0]        quo;
  logic [30:0]        ns_sum;
  logic               is_hip, is_a, out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign out_free = !out_valid_r || !out_stall;
  assign cur_sel  = pick_current(cur_r, joint_r);
  assign is_hip   = (joint_r == J_LEFT_HIP) || (joint_r == J_RIGHT_HIP);
  assign is_a     = (joint_r == J_LEFT_A) || (joint_r == J_RIGHT_A);
  assign vold     = vel_r[joint_r];
  assign pos      = ang_r[joint_r];

  // shared multiplier: gain times current, or the reciprocal step of the divide by 1000
  always_comb begin
    if (state_r == ST_DIV) begin
      mul_a = {4'b0000, x_r[31:3]};
      mul_b = {2'b00, RECIP_125};
    end else begin
      mul_a = is_hip ? {hip_gain_r[31], hip_gain_r} : {leg_gain_r[31], leg_gain_r};
      mul_b = amps_r;
    end
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (joint_r)
      J_LEFT_HIP: begin
        lo = LEFT_HIP_MIN;
        hi = LEFT_HIP_MAX;
      end
      J_RIGHT_HIP: begin
        lo = RIGHT_HIP_MIN;
        hi = RIGHT_HIP_MAX;
      end
      default: begin
        lo = is_a ? a_min_r : b_min_r;
        hi = is_a ? a_max_r : b_max_r;
      end
    endcase
  end

  assign v33    = {vwork_r[31], vwork_r};
  assign fric_s = {2'b00, fric_r};
  // gain product taken from its low 64 bits and shifted right by 16
  assign vsum   = {{18{vold[31]}}, vold} + {{2{prod_r[63]}}, prod_r[63:16]};
  assign quo    = prod_r[RECIP_SHIFT+26:RECIP_SHIFT];
  assign asum   = neg_r ? ({{18{pos[31]}}, pos} - {23'd0, quo})
                        : ({{18{pos[31]}}, pos} + {23'd0, quo});
  assign ns_sum = {1'b0, ns_r} + {1'b0, TICK_NS};

  // limit test against the old angle
  always_comb begin
    if (pos < lo && vwork_r < 0) begin
      vlim = '0;
    end else if (pos > hi && vwork_r > 0) begin
      vlim = '0;
    end else begin
      vlim = vwork_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    joint_nxt     = joint_r;
    cur_nxt       = cur_r;
    sec_nxt       = sec_r;
    ns_nxt        = ns_r;
    amps_nxt      = amps_r;
    prod_nxt      = prod_r;
    vwork_nxt     = vwork_r;
    x_nxt         = x_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_ang        = sat32(asum);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cur_nxt   = in_data;
          joint_nxt = J_LEFT_HIP;
          state_nxt = ST_AMP;
          if (ns_sum >= NS_PER_SEC) begin
            ns_nxt  = 30'(ns_sum - NS_PER_SEC);
            sec_nxt = sec_r + 32'd1;
          end else begin
            ns_nxt  = ns_sum[29:0];
          end
        end
      end
      ST_AMP: begin
        if (joint_r == J_LEFT_HIP) begin
          amps_nxt = {cur_sel[31], cur_sel} - {hip_hold_r[31], hip_hold_r};
        end else if (joint_r == J_RIGHT_HIP) begin
          amps_nxt = {cur_sel[31], cur_sel} + {hip_hold_r[31], hip_hold_r};
        end else begin
          amps_nxt = {cur_sel[31], cur_sel};
        end
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = ST_VEL;
      end
      ST_VEL: begin
        vwork_nxt = sat32(vsum);
        state_nxt = ST_FRIC;
      end
      ST_FRIC: begin
        // friction with dead zone, leg halves only
        if (!is_hip) begin
          if (v33 > fric_s) begin
            vwork_nxt = 32'(v33 - fric_s);
          end else if (v33 < -fric_s) begin
            vwork_nxt = 32'(v33 + fric_s);
          end else begin
            vwork_nxt = '0;
          end
        end
        state_nxt = ST_LIM;
      end
      ST_LIM: begin
        vwork_nxt = vlim;
        neg_nxt   = vlim[31];
        // magnitude plus half a step, for round half away from zero
        x_nxt     = vlim[31] ? (32'd501 + ~vlim) : (vlim + 32'd500);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        prod_nxt  = mul_p;
        state_nxt = ST_ANG;
      end
      ST_ANG: begin
        if (out_free) begin
          wr_en                     = 1'b1;
          out_valid_nxt             = 1'b1;
          out_nxt.joint_index       = joint_r;
          out_nxt.joint_angle       = wr_ang;
          out_nxt.joint_velocity    = vwork_r;
          out_nxt.stamp_seconds     = sec_r;
          out_nxt.stamp_nanoseconds = ns_r;
          out_nxt.last_of_tick      = (joint_r == J_RIGHT_B);
          if (joint_r == J_RIGHT_B) begin
            state_nxt = ST_IDLE;
          end else begin
            joint_nxt = joint_r + 3'd1;
            state_nxt = ST_AMP;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      joint_r     <= J_LEFT_HIP;
      out_valid_r <= 1'b0;
      sec_r       <= '0;
      ns_r        <= '0;
      hip_gain_r  <= '0;
      hip_hold_r  <= '0;
      leg_gain_r  <= '0;
      fric_r      <= '0;
      a_min_r     <= '0;
      a_max_r     <= '0;
      b_min_r     <= '0;
      b_max_r     <= '0;
      for (int i = 0; i < 6; i++) begin
        ang_r[i] <= reset_angle(3'(i));
        vel_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      joint_r     <= joint_nxt;
      out_valid_r <= out_valid_nxt;
      sec_r       <= sec_nxt;
      ns_r        <= ns_nxt;
      if (wr_en) begin
        ang_r[joint_r] <= wr_ang;
        vel_r[joint_r] <= vwork_r;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HIP_GAIN:     hip_gain_r <= cfg_data;
          CFG_HIP_HOLD:     hip_hold_r <= cfg_data;
          CFG_LEG_GAIN:     leg_gain_r <= cfg_data;
          CFG_LEG_FRICTION: fric_r     <= cfg_data[30:0];
          CFG_HALF_A_MIN:   a_min_r    <= cfg_data;
          CFG_HALF_A_MAX:   a_max_r    <= cfg_data;
          CFG_HALF_B_MIN:   b_min_r    <= cfg_data;
          CFG_HALF_B_MAX:   b_max_r    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    amps_r  <= amps_nxt;
    prod_r  <= prod_nxt;
    vwork_r <= vwork_nxt;
    x_r     <= x_nxt;
    neg_r   <= neg_nxt;
    out_r   <= out_nxt;
  end

endmodule

// File: hw/rtl/ljdt_checker.sv
// port-level assertions for the leg joint dynamics tick, bound to the top level
module ljdt_checker import ljdt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input ljdt_out_t out_data
);

  // a tick occupies the block, so no request is taken right after one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_last_marks_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_of_tick == (out_data.joint_index == J_RIGHT_B)))
    else $error("last_of_tick does not match the final joint");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.joint_index <= J_RIGHT_B)
    else $error("joint index out of range");

  a_ns_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_data.stamp_nanoseconds} < NS_PER_SEC)
    else $error("nanoseconds not below one second");

endmodule

bind leg_joint_dynamics_tick ljdt_checker u_ljdt_checker (.*);
